>>> rtl/rrht_pkg.sv
// Package for the ray/rectangle hit test: widths, register indexes, constants.
// No dependencies.
package rrht_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned NormW    = 18;
  localparam int unsigned EdgeW    = 31;
  localparam int unsigned DistW    = 31;
  localparam int unsigned NumW     = 52;
  localparam int unsigned DenW     = 52;
  localparam int unsigned QuotW    = 52;
  localparam int unsigned DivSteps = 52;
  localparam int unsigned FracSteps = 16;
  localparam int unsigned DivStepsPerStage = 4;
  localparam int unsigned DivStages = (DivSteps + FracSteps) / DivStepsPerStage;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [DistW-1:0] MinDistance = 31'd66;
  localparam logic [DistW-1:0] TMax        = 31'h7FFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegCornerX   = 3'd0,
    RegCornerY   = 3'd1,
    RegCornerZ   = 3'd2,
    RegNormalX   = 3'd3,
    RegNormalY   = 3'd4,
    RegNormalZ   = 3'd5,
    RegEdgeWidth = 3'd6,
    RegEdgeLen   = 3'd7
  } reg_idx_e;

  // Per-item data carried alongside the divider.
  typedef struct packed {
    logic                     live;
    logic signed [CoordW-1:0] ox, oy, oz;
    logic signed [CoordW-1:0] dx, dy, dz;
  } ray_t;

  // Divider lane state: remainder, divisor, quotient bits built so far.
  typedef struct packed {
    logic [DenW:0]      rem;
    logic [DenW-1:0]    den;
    logic [NumW-1:0]    num;
    logic [QuotW+15:0]  quo;
  } div_t;

endpackage

>>> rtl/rrht_div_stage.sv
// One divider stage: a few restoring divide steps on the division lane.
// Depends on rrht_pkg.
module rrht_div_stage
  import rrht_pkg::*;
(
  input  div_t in_i,
  output div_t out_o
);

  div_t s [DivStepsPerStage+1];
  logic [DenW:0] trial;

  always_comb begin
    s[0] = in_i;
    trial = '0;
    for (int k = 0; k < DivStepsPerStage; k++) begin
      s[k+1] = s[k];
      trial = {s[k].rem[DenW-1:0], s[k].num[NumW-1]};
      s[k+1].num = {s[k].num[NumW-2:0], 1'b0};
      if (trial >= {1'b0, s[k].den}) begin
        s[k+1].rem = trial - {1'b0, s[k].den};
        s[k+1].quo = {s[k].quo[QuotW+14:0], 1'b1};
      end else begin
        s[k+1].rem = trial;
        s[k+1].quo = {s[k].quo[QuotW+14:0], 1'b0};
      end
    end
    out_o = s[DivStepsPerStage];
  end

endmodule

>>> rtl/ray_rectangle_hit_test.sv
// Top level of the ray/rectangle hit test: configuration registers, dot products,
// pipelined divider, hit point and bounds check. Depends on rrht_pkg, rrht_div_stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  ray     | in        | in_valid_i/in_stall_o   | origin_*_i, dir_*_i
//  result  | out       | out_valid_o/out_stall_i | hit_o, distance_o, hit_*_o, out_normal_*_o
//  config  | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item enters per cycle while the output is not stalled. The pipe has 3 + DivStages
// + 4 = 24 register stages: three front stages (corner differences, products, sums),
// DivStages = 17 divider stages of four restoring steps (52 numerator steps and 16
// fraction steps), then t, dir * t, hit point and output stages. Reset clears every
// stage and loads the register reset values. A stall at the output freezes the whole
// pipe; the input is stalled exactly then, so no item is lost.
module ray_rectangle_hit_test
  import rrht_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [CoordW-1:0]  origin_x_i,
  input  logic signed [CoordW-1:0]  origin_y_i,
  input  logic signed [CoordW-1:0]  origin_z_i,
  input  logic signed [CoordW-1:0]  dir_x_i,
  input  logic signed [CoordW-1:0]  dir_y_i,
  input  logic signed [CoordW-1:0]  dir_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [DistW-1:0]          distance_o,
  output logic signed [CoordW-1:0]  hit_x_o,
  output logic signed [CoordW-1:0]  hit_y_o,
  output logic signed [CoordW-1:0]  hit_z_o,
  output logic signed [NormW-1:0]   out_normal_x_o,
  output logic signed [NormW-1:0]   out_normal_y_o,
  output logic signed [NormW-1:0]   out_normal_z_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CoordW-1:0]         cfg_data_i
);

  // The pipe advances whenever the output is not stalled. A bubble is just a
  // stage whose valid bit is low.
  logic adv;
  assign adv        = !out_stall_i;
  assign in_stall_o = out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
  logic signed [NormW-1:0]  nx_q, ny_q, nz_q;
  logic [EdgeW-1:0]         ew_q, el_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= -32'sd65536;
      cy_q <= '0;
      cz_q <= -32'sd65536;
      nx_q <= '0;
      ny_q <= 18'sd65536;
      nz_q <= '0;
      ew_q <= 31'd65536;
      el_q <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegCornerX:   cx_q <= cfg_data_i;
        RegCornerY:   cy_q <= cfg_data_i;
        RegCornerZ:   cz_q <= cfg_data_i;
        RegNormalX:   nx_q <= cfg_data_i[NormW-1:0];
        RegNormalY:   ny_q <= cfg_data_i[NormW-1:0];
        RegNormalZ:   nz_q <= cfg_data_i[NormW-1:0];
        RegEdgeWidth: ew_q <= cfg_data_i[EdgeW-1:0];
        RegEdgeLen:   el_q <= cfg_data_i[EdgeW-1:0];
        default:      ;
      endcase
    end
  end

  // Stage 1: register the ray and the corner differences (33 bits each).
  ray_t s1_q;
  logic signed [CoordW:0] e_x_q, e_y_q, e_z_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      e_x_q <= '0;
      e_y_q <= '0;
      e_z_q <= '0;
    end else if (adv) begin
      s1_q.live <= in_valid_i;
      s1_q.ox <= origin_x_i; s1_q.oy <= origin_y_i; s1_q.oz <= origin_z_i;
      s1_q.dx <= dir_x_i;    s1_q.dy <= dir_y_i;    s1_q.dz <= dir_z_i;
      e_x_q <= 33'(cx_q) - 33'(origin_x_i);
      e_y_q <= 33'(cy_q) - 33'(origin_y_i);
      e_z_q <= 33'(cz_q) - 33'(origin_z_i);
    end
  end

  // Stage 2: six products, one multiplier each.
  ray_t s2_q;
  logic signed [50:0] pn_x_q, pn_y_q, pn_z_q;
  logic signed [49:0] pd_x_q, pd_y_q, pd_z_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q   <= '0;
      pn_x_q <= '0; pn_y_q <= '0; pn_z_q <= '0;
      pd_x_q <= '0; pd_y_q <= '0; pd_z_q <= '0;
    end else if (adv) begin
      s2_q   <= s1_q;
      pn_x_q <= 51'(e_x_q) * 51'(nx_q);
      pn_y_q <= 51'(e_y_q) * 51'(ny_q);
      pn_z_q <= 51'(e_z_q) * 51'(nz_q);
      pd_x_q <= 50'(s1_q.dx) * 50'(nx_q);
      pd_y_q <= 50'(s1_q.dy) * 50'(ny_q);
      pd_z_q <= 50'(s1_q.dz) * 50'(nz_q);
    end
  end

  // Stage 3: sums, sign test and magnitudes; loads the divider lane.
  logic signed [NumW:0] num_c;
  logic signed [DenW:0] den_c;
  logic                 ok_c;
  assign num_c = 53'(pn_x_q) + 53'(pn_y_q) + 53'(pn_z_q);
  assign den_c = 53'(pd_x_q) + 53'(pd_y_q) + 53'(pd_z_q);
  assign ok_c  = (num_c != '0) && (den_c != '0) && (num_c[NumW] == den_c[NumW]);

  ray_t s3_q;
  div_t d3_q;
  logic ok3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q  <= '0;
      d3_q  <= '0;
      ok3_q <= 1'b0;
    end else if (adv) begin
      s3_q  <= s2_q;
      ok3_q <= ok_c;
      d3_q.rem <= '0;
      d3_q.quo <= '0;
      d3_q.num <= num_c[NumW] ? NumW'(-num_c) : num_c[NumW-1:0];
      d3_q.den <= den_c[DenW] ? DenW'(-den_c) : den_c[DenW-1:0];
    end
  end

  // Divider pipe. One step for each numerator bit, then 16 fraction steps fed with
  // zero bits (the numerator shifts in zeros once exhausted, so all steps are uniform).
  // The quotient is floor(|num| * 2^16 / |den|) with every integer bit kept.
  ray_t dr_q  [DivStages];
  div_t dv_q  [DivStages];
  logic dok_q [DivStages];
  div_t dv_c  [DivStages];

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    rrht_div_stage u_stage (
      .in_i  (g == 0 ? d3_q : dv_q[(g == 0) ? 0 : g-1]),
      .out_o (dv_c[g])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dr_q[g]  <= '0;
        dv_q[g]  <= '0;
        dok_q[g] <= 1'b0;
      end else if (adv) begin
        dv_q[g]  <= dv_c[g];
        dr_q[g]  <= (g == 0) ? s3_q : dr_q[(g == 0) ? 0 : g-1];
        dok_q[g] <= (g == 0) ? ok3_q : dok_q[(g == 0) ? 0 : g-1];
      end
    end
  end

  // Stage T: t from the quotient, saturation and the epsilon test.
  div_t dl;
  assign dl = dv_q[DivStages-1];
  ray_t rt_q;
  logic [DistW-1:0] t_q;
  logic tok_q;
  logic [QuotW+15:0] qfull;
  assign qfull = dl.quo;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q  <= '0;
      t_q   <= '0;
      tok_q <= 1'b0;
    end else if (adv) begin
      rt_q  <= dr_q[DivStages-1];
      t_q   <= (qfull[QuotW+15:31] != '0) ? TMax : qfull[DistW-1:0];
      tok_q <= dok_q[DivStages-1];
    end
  end
  logic tok_c;
  assign tok_c = tok_q && (t_q > MinDistance);

  // Stage P: products dir * t.
  ray_t rp_q;
  logic [DistW-1:0] tp_q;
  logic pok_q;
  logic signed [63:0] m_x_q, m_y_q, m_z_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      tp_q  <= '0;
      pok_q <= 1'b0;
      m_x_q <= '0; m_y_q <= '0; m_z_q <= '0;
    end else if (adv) begin
      rp_q  <= rt_q;
      tp_q  <= t_q;
      pok_q <= tok_c;
      m_x_q <= 64'(rt_q.dx) * $signed({33'd0, t_q});
      m_y_q <= 64'(rt_q.dy) * $signed({33'd0, t_q});
      m_z_q <= 64'(rt_q.dz) * $signed({33'd0, t_q});
    end
  end

  // Stage H: hit point (arithmetic shift is floor).
  logic signed [48:0] p_x_c, p_y_c, p_z_c;
  assign p_x_c = 49'(rp_q.ox) + 49'(m_x_q >>> 16);
  assign p_y_c = 49'(rp_q.oy) + 49'(m_y_q >>> 16);
  assign p_z_c = 49'(rp_q.oz) + 49'(m_z_q >>> 16);

  logic hv_q, hok_q;
  logic [DistW-1:0] th_q;
  logic signed [48:0] p_x_q, p_y_q, p_z_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      hok_q <= 1'b0;
      th_q  <= '0;
      p_x_q <= '0; p_y_q <= '0; p_z_q <= '0;
    end else if (adv) begin
      hv_q  <= rp_q.live;
      hok_q <= pok_q;
      th_q  <= tp_q;
      p_x_q <= p_x_c; p_y_q <= p_y_c; p_z_q <= p_z_c;
    end
  end

  // Stage O: offsets, bounds test and saturation into the output register.
  logic signed [49:0] ofx_c, ofz_c;
  logic             in_c;
  assign ofx_c = 50'(p_x_q) - 50'(cx_q);
  assign ofz_c = 50'(p_z_q) - 50'(cz_q);
  assign in_c  = hok_q && !ofx_c[49] && (ofx_c <= 50'(ew_q))
                       && !ofz_c[49] && (ofz_c <= 50'(el_q));

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647)        return 32'sh7FFF_FFFF;
    else if (v < -49'sd2147483648)  return 32'sh8000_0000;
    else                            return v[CoordW-1:0];
  endfunction

  logic ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q           <= 1'b0;
      hit_o          <= 1'b0;
      distance_o     <= '0;
      hit_x_o        <= '0;
      hit_y_o        <= '0;
      hit_z_o        <= '0;
      out_normal_x_o <= '0;
      out_normal_y_o <= '0;
      out_normal_z_o <= '0;
    end else if (adv) begin
      ov_q           <= hv_q;
      hit_o          <= in_c;
      distance_o     <= in_c ? th_q : '0;
      hit_x_o        <= in_c ? sat32(p_x_q) : '0;
      hit_y_o        <= in_c ? sat32(p_y_q) : '0;
      hit_z_o        <= in_c ? sat32(p_z_q) : '0;
      out_normal_x_o <= in_c ? nx_q : '0;
      out_normal_y_o <= in_c ? ny_q : '0;
      out_normal_z_o <= in_c ? nz_q : '0;
    end
  end
  assign out_valid_o = ov_q;

endmodule

>>> test/tb.sv
// Self-checking testbench for ray_rectangle_hit_test: a directed table, then random rays.
// Depends on rrht_pkg and the ray_rectangle_hit_test RTL; predicts each untyped result.
`timescale 1ns / 100ps

module tb;
  import rrht_pkg::*;

  // The pipe has 3 + DivStages + 4 register stages; allow margin.
  localparam int unsigned SettleCycles = 3 + DivStages + 4 + 20;
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned PhaseItems   = 300;

  typedef struct {
    logic                     hit;
    logic [DistW-1:0]         t_val;
    logic signed [CoordW-1:0] hx, hy, hz;
    logic signed [NormW-1:0]  nx, ny, nz;
  } hit_res_t;

  typedef struct {
    logic signed [CoordW-1:0] o[3];
    logic signed [CoordW-1:0] d[3];
  } ray_in_t;

  // A directed row either carries a typed-in result or leaves it to the predictor.
  typedef struct {
    bit       typed;
    ray_in_t  ray;
    hit_res_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [CoordW-1:0] org_x = '0, org_y = '0, org_z = '0;
  logic signed [CoordW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     hit;
  logic [DistW-1:0]         distance;
  logic signed [CoordW-1:0] hit_x, hit_y, hit_z;
  logic signed [NormW-1:0]  onx, ony, onz;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIdxW-1:0]       cfg_index = '0;
  logic [CoordW-1:0]        cfg_data = '0;

  // Shadow copy of the rectangle registers, masked to their widths.
  logic [CoordW-1:0] rect_reg [8];

  hit_res_t pending_hits[$];
  bit       failed = 1'b0;
  bit       quiet = 1'b0;   // no idling on either side while set
  int       cycles = 0;

  always #4 clk = ~clk;

  ray_rectangle_hit_test DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .origin_x_i(org_x), .origin_y_i(org_y), .origin_z_i(org_z),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_o(hit), .distance_o(distance),
    .hit_x_o(hit_x), .hit_y_o(hit_y), .hit_z_o(hit_z),
    .out_normal_x_o(onx), .out_normal_y_o(ony), .out_normal_z_o(onz),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic logic [CoordW-1:0] reg_mask(int idx);
    if (idx >= RegNormalX && idx <= RegNormalZ) return 32'h0003_FFFF;
    if (idx >= RegEdgeWidth) return 32'h7FFF_FFFF;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Exact plane distance, restoring long division to unsigned Q15.16, then the bounds test.
  function automatic hit_res_t predict_hit(ray_in_t ray);
    hit_res_t res;
    longint o[3], d[3], c[3], n[3], p[3];
    longint num, den, un, ud, q, r, t, ofs_x, ofs_z;
    res = '{default: '0};
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(ray.o[i]);
      d[i] = longint'(ray.d[i]);
      c[i] = longint'($signed(rect_reg[i]));
      n[i] = longint'($signed(rect_reg[3+i][NormW-1:0]));
      num += (c[i] - o[i]) * n[i];
      den += n[i] * d[i];
    end
    if (den == 0 || num == 0 || ((num < 0) != (den < 0))) return res;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = un / ud;
    if (q >= 32768) begin
      t = longint'(TMax);
    end else begin
      r = un % ud;
      t = q;
      for (int i = 0; i < 16; i++) begin
        r = r <<< 1;
        t = t <<< 1;
        if (r >= ud) begin
          r -= ud;
          t |= 1;
        end
      end
    end
    if (t <= longint'(MinDistance)) return res;
    // An arithmetic shift of the signed product is the floor division by 2^16.
    for (int i = 0; i < 3; i++) p[i] = o[i] + ((d[i] * t) >>> 16);
    ofs_x = p[0] - c[0];
    ofs_z = p[2] - c[2];
    if (ofs_x < 0 || ofs_x > longint'(rect_reg[RegEdgeWidth])) return res;
    if (ofs_z < 0 || ofs_z > longint'(rect_reg[RegEdgeLen])) return res;
    res.hit   = 1'b1;
    res.t_val = t[DistW-1:0];
    res.hx    = 32'(clamp32(p[0]));
    res.hy    = 32'(clamp32(p[1]));
    res.hz    = 32'(clamp32(p[2]));
    res.nx    = rect_reg[RegNormalX][NormW-1:0];
    res.ny    = rect_reg[RegNormalY][NormW-1:0];
    res.nz    = rect_reg[RegNormalZ][NormW-1:0];
    return res;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int idle_len();
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic wait_drained();
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Holds one register write until accepted; the caller drops the valid afterwards.
  task automatic write_reg(int idx, logic [CoordW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CfgIdxW-1:0];
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rect_reg[idx] = data & reg_mask(idx);
  endtask

  task automatic write_rect(logic [CoordW-1:0] vals[8]);
    for (int i = 0; i < 8; i++) write_reg(i, vals[i]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drives one ray and holds it until accepted; the expectation is queued on acceptance.
  task automatic send_ray(ray_in_t ray, bit typed, hit_res_t typed_res);
    int gap;
    in_valid <= 1'b1;
    org_x <= ray.o[0];
    org_y <= ray.o[1];
    org_z <= ray.o[2];
    dir_x <= ray.d[0];
    dir_y <= ray.d[1];
    dir_z <= ray.d[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hits.push_back(typed ? typed_res : predict_hit(ray));
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [CoordW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A ray aimed at a point on a horizontal rectangle so that t is a whole multiple of one,
  // plus a small nudge that moves the point across the edges now and then.
  function automatic ray_in_t aimed_ray();
    ray_in_t ray;
    longint tgt[3], dv, k;
    tgt[0] = longint'($signed(rect_reg[RegCornerX])) +
             longint'($urandom_range(0, 1000)) * longint'(rect_reg[RegEdgeWidth]) / 1000;
    tgt[1] = longint'($signed(rect_reg[RegCornerY]));
    tgt[2] = longint'($signed(rect_reg[RegCornerZ])) +
             longint'($urandom_range(0, 1000)) * longint'(rect_reg[RegEdgeLen]) / 1000;
    if ($urandom_range(0, 3) == 0) begin
      tgt[0] += $signed($urandom_range(0, 8)) - 4;
      tgt[2] += $signed($urandom_range(0, 8)) - 4;
    end
    k = $urandom_range(1, 4);
    for (int i = 0; i < 3; i++) begin
      dv = longint'($signed($urandom_range(0, 32'h0004_0000))) - 64'sh0002_0000;
      if (i == 1 && dv == 0) dv = 65536;
      ray.d[i] = 32'(dv);
      ray.o[i] = 32'(clamp32(tgt[i] - dv * k));
    end
    return ray;
  endfunction

  function automatic ray_in_t noise_ray();
    ray_in_t ray;
    for (int i = 0; i < 3; i++) begin
      ray.o[i] = rand_word();
      ray.d[i] = rand_word();
    end
    return ray;
  endfunction

  // Output side: random stall, with stretches of none while quiet is set.
  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet) out_stall <= 1'b0;
    else if (out_stall) out_stall <= (pick < 60) || (pick >= 97);
    else out_stall <= (pick < 25);
  end

  task automatic check_field(string name, longint exp, longint act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      failed = 1'b1;
    end
  endtask

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    hit_res_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $error("result item with no expectation pending");
        failed = 1'b1;
      end else begin
        exp = pending_hits.pop_front();
        check_field("hit", exp.hit, hit);
        check_field("distance", exp.t_val, distance);
        check_field("hit_x", exp.hx, hit_x);
        check_field("hit_y", exp.hy, hit_y);
        check_field("hit_z", exp.hz, hit_z);
        check_field("out_normal_x", exp.nx, onx);
        check_field("out_normal_y", exp.ny, ony);
        check_field("out_normal_z", exp.nz, onz);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic ray_in_t mk_ray(longint ox, longint oy, longint oz,
                                     longint dx, longint dy, longint dz);
    ray_in_t ray;
    ray.o[0] = 32'(ox); ray.o[1] = 32'(oy); ray.o[2] = 32'(oz);
    ray.d[0] = 32'(dx); ray.d[1] = 32'(dy); ray.d[2] = 32'(dz);
    return ray;
  endfunction

  initial begin
    table_row_t       rows[$];
    hit_res_t         miss, center;
    logic [CoordW-1:0] vals[8];

    rect_reg[RegCornerX]   = 32'hFFFF_0000;
    rect_reg[RegCornerY]   = 32'h0;
    rect_reg[RegCornerZ]   = 32'hFFFF_0000;
    rect_reg[RegNormalX]   = 32'h0;
    rect_reg[RegNormalY]   = 32'h0001_0000;
    rect_reg[RegNormalZ]   = 32'h0;
    rect_reg[RegEdgeWidth] = 32'h0001_0000;
    rect_reg[RegEdgeLen]   = 32'h0001_0000;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    miss = '{default: '0};
    center = '{hit: 1'b1, t_val: 31'd65536, hx: 0, hy: 0, hz: 0,
               nx: 0, ny: 18'sd65536, nz: 0};

    // Reset rectangle: corner (-1,0,-1), normal +y, one unit on each side.
    rows.push_back('{1, mk_ray(0, 65536, 0, 0, -65536, 0), center});
    rows.push_back('{1, mk_ray(0, 65536, 0, 65536, 0, 0), miss});      // parallel ray
    rows.push_back('{1, mk_ray(0, 65536, 0, 0, 65536, 0), miss});      // pointing away
    rows.push_back('{1, mk_ray(0, 0, 0, 0, -65536, 0), miss});         // origin on the plane
    rows.push_back('{1, mk_ray(0, 1, 0, 0, -65536, 0), miss});         // t below epsilon
    rows.push_back('{1, mk_ray(0, 66, 0, 0, -65536, 0), miss});        // t at epsilon
    rows.push_back('{0, mk_ray(0, 67, 0, 0, -65536, 0), miss});        // just past epsilon
    rows.push_back('{0, mk_ray(-65536, 65536, -65536, 0, -65536, 0), miss}); // corner
    rows.push_back('{0, mk_ray(0, 65536, 0, 0, -65536, 0), miss});     // center again, predicted
    rows.push_back('{1, mk_ray(65537, 65536, 0, 0, -65536, 0), miss}); // just outside in x
    rows.push_back('{1, mk_ray(0, 65536, -65537, 0, -65536, 0), miss});// just outside in z
    rows.push_back('{0, mk_ray(0, 32'sh7FFF_FFFF, 0, 0, -1, 0), miss}); // huge t saturates
    rows.push_back('{0, mk_ray(0, -64'sd2147483648, 0, 0, 32'sh7FFF_FFFF, 0), miss});
    rows.push_back('{0, mk_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                               -64'sd2147483648, -64'sd2147483648, -64'sd2147483648), miss});
    rows.push_back('{0, mk_ray(-64'sd2147483648, 65536, -64'sd2147483648,
                               32'sh7FFF_FFFF, -65536, 32'sh7FFF_FFFF), miss});
    rows.push_back('{0, mk_ray(0, 131072, 0, 1000, -65536, -1000), miss});
    rows.push_back('{0, mk_ray(0, 65536, 0, 0, -1, 0), miss});
    rows.push_back('{0, mk_ray(-1, -1, -1, -1, -1, -1), miss});
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
    in_valid <= 1'b0;
    wait_drained();

    // Random phases; each drains before the rectangle is rewritten.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin  // horizontal rectangle, moderate coordinates
          vals = '{$urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                   $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                   $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000,
                   0, 32'h0001_0000, 0,
                   $urandom_range(1, 32'h0040_0000), $urandom_range(1, 32'h0040_0000)};
        end
        1: begin  // facing down, zero width, widest length
          vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   0, 32'h0003_0000, 0, 0, 32'h7FFF_FFFF};
        end
        2: begin  // upper corner extreme, zero length, widest width
          vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   0, 32'h0001_0000, 0, 32'h7FFF_FFFF, 0};
        end
        3: begin  // tilted normal with components of -1 and +1
          vals = '{$urandom_range(0, 32'h0003_FFFF), 0, $urandom_range(0, 32'h0003_FFFF),
                   32'h0003_0000, 32'h0001_0000, 32'h0001_0000,
                   $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF)};
        end
        4: begin  // everything random, upper bits beyond the register widths included
          foreach (vals[i]) vals[i] = $urandom();
        end
        default: begin
          vals = '{$urandom_range(0, 32'h0000_FFFF) - 32'h0000_8000, $urandom(), 0,
                   0, 32'h0001_0000, 0, $urandom_range(0, 32'h0010_0000), 32'h0001_0000};
        end
      endcase
      write_rect(vals);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (rect_reg[RegNormalX][NormW-1:0] == 0 && rect_reg[RegNormalZ][NormW-1:0] == 0 &&
            $urandom_range(0, 99) < 70)
          send_ray(aimed_ray(), 0, miss);
        else
          send_ray(noise_ray(), 0, miss);
      end
      in_valid <= 1'b0;
      quiet = 1'b0;
      // The sender holds off here until every result of the phase has come back.
      wait_drained();
    end

    if (!failed && pending_hits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
